// ===== hw/rtl/pha_pkg.sv =====
// ---------------------------------------------------------------------------
// pha_pkg
// Types and codes shared by the pixel hit accumulator modules.
// ---------------------------------------------------------------------------
`default_nettype none
package pha_pkg;

    localparam int PIX_W    = 10;
    localparam int POS_W    = 32;
    localparam int ENERGY_W = 24;
    localparam int SUM_W    = 32;
    localparam int ID_W     = 31;
    localparam int PCODE_W  = 32;
    localparam int IN_DATA_W  = 240;
    localparam int OUT_DATA_W = 248;

    // input word kinds
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // result word kinds
    localparam logic [1:0] STATUS_ENTRY = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_DROP  = 2'd2;

    // one table entry payload
    typedef struct packed {
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [POS_W-1:0]   z;
        logic [SUM_W-1:0]          energy;
        logic [ID_W-1:0]           track;
        logic signed [PCODE_W-1:0] particle;
        logic                      pflag;
        logic [ID_W-1:0]           pid;
    } t_entry;

    // one input deposit (mode travels separately)
    typedef struct packed {
        logic [PIX_W-1:0]          col;
        logic [PIX_W-1:0]          row;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [POS_W-1:0]   z;
        logic [ENERGY_W-1:0]       energy;
        logic [ID_W-1:0]           track;
        logic signed [PCODE_W-1:0] particle;
        logic                      prim;
        logic [ID_W-1:0]           pid;
    } t_deposit;

    // one result word
    typedef struct packed {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        t_entry           ent;
        logic [1:0]       status;
        logic             last;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clear;
        logic new_entry;
        logic drop;
        logic rd_lookup;
        logic rmw_write;
        logic flush_start;
        logic scan_step;
        logic next_run;
        logic rd_best;
        logic load_entry;
        logic load_empty;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit_any;
        logic free_any;
        logic table_empty;
        logic scan_last;
        logic out_taken;
        logic out_last;
    } t_status;

endpackage
`default_nettype wire

// ===== hw/rtl/pha_ctrl.sv =====
// ---------------------------------------------------------------------------
// pha_ctrl
// Sequencer for deposit lookup/update, table clear and sorted flush.
// ---------------------------------------------------------------------------
`default_nettype none
module pha_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [1:0]       i_mode,
    output logic                  o_in_ready,
    input  wire pha_pkg::t_status i_sts,
    output pha_pkg::t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_RMW  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_LOAD = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] r_state, n_state;
    logic       in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_mode)
                        pha_pkg::MODE_ADD: n_state = S_LOOK;
                        pha_pkg::MODE_CLEAR: o_cmd.clear = 1'b1;
                        pha_pkg::MODE_FLUSH: begin
                            if (i_sts.table_empty) begin
                                o_cmd.load_empty = 1'b1;
                                n_state = S_EMIT;
                            end else begin
                                o_cmd.flush_start = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOK: begin
                if (i_sts.hit_any) begin
                    o_cmd.rd_lookup = 1'b1;
                    n_state = S_RMW;
                end else if (i_sts.free_any) begin
                    o_cmd.new_entry = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.drop = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RMW: begin
                o_cmd.rmw_write = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd_best = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_entry = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_run = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pha_dp.sv =====
// ---------------------------------------------------------------------------
// pha_dp
// Key match array, entry memory, energy update and sorted flush scan.
// ---------------------------------------------------------------------------
`default_nettype none
module pha_dp #(
    parameter int TABLE_ENTRIES = 64,
    parameter int INDEX_BITS    = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pha_pkg::t_deposit i_dep,
    input  wire pha_pkg::t_cmd     i_cmd,
    output pha_pkg::t_status       o_sts,
    output pha_pkg::t_result       o_out,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int CW    = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W = 2 * INDEX_BITS;

    // key store and match
    logic [TABLE_ENTRIES-1:0] r_used;
    logic [KEY_W-1:0]         r_key [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_hit;
    logic [KEY_W-1:0]         kin;

    // captured deposit
    pha_pkg::t_deposit r_dep;
    logic [KEY_W-1:0]  r_kin;

    // entry memory
    pha_pkg::t_entry mem [TABLE_ENTRIES];
    pha_pkg::t_entry r_rd;
    pha_pkg::t_entry wr_data, upd, fresh;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic            wr_en;

    logic [AW-1:0] hit_idx, free_idx;
    logic          hit_any, free_any;

    logic [CW-1:0] r_count, r_emit;
    logic          r_dropped;

    // flush scan
    logic [AW-1:0]    r_scan, r_best_idx;
    logic [KEY_W-1:0] r_best_key, r_prev, scan_key;
    logic             r_best_ok, r_have_prev, scan_take;

    pha_pkg::t_result r_out;
    logic             r_ovalid;
    logic [pha_pkg::SUM_W:0] esum;

    assign kin = {INDEX_BITS'(i_dep.col), INDEX_BITS'(i_dep.row)};

    // lowest hit and lowest free slot
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        hit_any  = 1'b0;
        free_any = 1'b0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                hit_idx = AW'(i);
                hit_any = 1'b1;
            end
            if (!r_used[i]) begin
                free_idx = AW'(i);
                free_any = 1'b1;
            end
        end
    end

    // new entry from the first deposit; update of an existing entry
    always_comb begin
        fresh.x        = r_dep.x;
        fresh.y        = r_dep.y;
        fresh.z        = r_dep.z;
        fresh.energy   = pha_pkg::SUM_W'(r_dep.energy);
        fresh.track    = r_dep.track;
        fresh.particle = r_dep.particle;
        fresh.pflag    = r_dep.prim;
        fresh.pid      = r_dep.pid;

        esum = {1'b0, r_rd.energy} + (pha_pkg::SUM_W + 1)'(r_dep.energy);
        upd  = r_rd;
        upd.energy = esum[pha_pkg::SUM_W] ? '1 : esum[pha_pkg::SUM_W-1:0];
        if (r_dep.track < r_rd.track) begin
            upd.track    = r_dep.track;
            upd.particle = r_dep.particle;
        end
        upd.pflag = r_rd.pflag | r_dep.prim;
        if (r_dep.pid < r_rd.pid) upd.pid = r_dep.pid;
    end

    assign wr_en   = i_cmd.new_entry || i_cmd.rmw_write;
    assign wr_addr = i_cmd.new_entry ? free_idx : r_best_idx;
    assign wr_data = i_cmd.new_entry ? fresh : upd;
    assign rd_addr = i_cmd.rd_lookup ? hit_idx : r_best_idx;

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    // key array, captured deposit and match vector
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dep <= i_dep;
            r_kin <= kin;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                r_hit[i] <= r_used[i] && (r_key[i] == kin);
        end
        if (i_cmd.new_entry) r_key[free_idx] <= r_kin;
    end

    // table occupancy and dropped flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.clear) begin
            r_used    <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (i_cmd.new_entry) begin
                r_used[free_idx] <= 1'b1;
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.drop) r_dropped <= 1'b1;
        end
    end

    // scan candidate: smallest key above the previous one
    assign scan_key  = r_key[r_scan];
    assign scan_take = r_used[r_scan] && (!r_have_prev || scan_key > r_prev)
                       && (!r_best_ok || scan_key < r_best_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_best_ok   <= 1'b0;
            r_have_prev <= 1'b0;
            r_emit      <= '0;
        end else if (i_cmd.flush_start || i_cmd.next_run) begin
            r_scan      <= '0;
            r_best_ok   <= 1'b0;
            r_have_prev <= i_cmd.next_run;
            r_emit      <= i_cmd.next_run ? r_emit + CW'(1) : '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + AW'(1);
            if (scan_take) r_best_ok <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_lookup) r_best_idx <= hit_idx;
        if (i_cmd.scan_step && scan_take) begin
            r_best_idx <= r_scan;
            r_best_key <= scan_key;
        end
        if (i_cmd.next_run) r_prev <= r_best_key;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_empty) begin
            r_out.col    <= '0;
            r_out.row    <= '0;
            r_out.ent    <= '0;
            r_out.status <= pha_pkg::STATUS_EMPTY;
            r_out.last   <= 1'b1;
        end else if (i_cmd.load_entry) begin
            r_out.col    <= pha_pkg::PIX_W'(r_best_key[KEY_W-1:INDEX_BITS]);
            r_out.row    <= pha_pkg::PIX_W'(r_best_key[INDEX_BITS-1:0]);
            r_out.ent    <= r_rd;
            r_out.status <= r_dropped ? pha_pkg::STATUS_DROP : pha_pkg::STATUS_ENTRY;
            r_out.last   <= (r_emit + CW'(1)) == r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                              r_ovalid <= 1'b0;
        else if (i_cmd.load_empty || i_cmd.load_entry) r_ovalid <= 1'b1;
        else if (i_out_ready)                      r_ovalid <= 1'b0;
    end

    assign o_out       = r_out;
    assign o_out_valid = r_ovalid;

    assign o_sts.hit_any     = hit_any;
    assign o_sts.free_any    = free_any;
    assign o_sts.table_empty = (r_count == '0);
    assign o_sts.scan_last   = (r_scan == AW'(TABLE_ENTRIES - 1));
    assign o_sts.out_taken   = r_ovalid && i_out_ready;
    assign o_sts.out_last    = r_out.last;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("fill count above table size");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_count == '0) && (r_used == '0) && !r_dropped)
        else $error("clear left table occupied");
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_out.status == pha_pkg::STATUS_EMPTY) |-> r_out.last)
        else $error("empty marker not last");
    a_load_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_best |-> r_best_ok)
        else $error("flush scan found no entry");
    a_new_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.new_entry |-> !hit_any && !r_used[free_idx])
        else $error("new entry over used slot");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/pixel_hit_accumulator_unit.sv =====
// A deposit to a new key passes the accepting and lookup states; one to a known key
// also passes a read-modify-write state. Clear and unused modes are handled in the
// accepting state; no word is produced for them. Flush: each result word takes a full
// key scan through one compare unit, then one entry memory read, plus output waiting.
// An empty flush presents its marker word in the cycle after acceptance.
// Reset (i_rst_n low, synchronous) empties the table at once; no clear pass.
// ---------------------------------------------------------------------------
// pixel_hit_accumulator_unit
// Per-event pixel table collecting energy deposits, flushed in key order.
// ---------------------------------------------------------------------------
`default_nettype none
module pixel_hit_accumulator_unit #(
    parameter int TABLE_ENTRIES = 64,
    parameter int INDEX_BITS    = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pixel_col, pixel_row, pos_x, pos_y, pos_z, energy, track_id,
    // particle_code, is_primary, primary_id
    input  wire logic [pha_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // mode
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // out_col, out_row, out_x, out_y, out_z, out_energy, out_track,
    // out_particle, out_primary, out_primary_id
    output logic [pha_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // status
    output logic [1:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast
);

    pha_pkg::t_deposit dep;
    pha_pkg::t_cmd     cmd;
    pha_pkg::t_status  sts;
    pha_pkg::t_result  res;

    // unpack input word
    assign dep.col      = s_axis_tdata[9:0];
    assign dep.row      = s_axis_tdata[19:10];
    assign dep.x        = s_axis_tdata[51:20];
    assign dep.y        = s_axis_tdata[83:52];
    assign dep.z        = s_axis_tdata[115:84];
    assign dep.energy   = s_axis_tdata[139:116];
    assign dep.track    = s_axis_tdata[170:140];
    assign dep.particle = s_axis_tdata[202:171];
    assign dep.prim     = s_axis_tdata[203];
    assign dep.pid      = s_axis_tdata[234:204];

    pha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pha_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .INDEX_BITS    (INDEX_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dep       (dep),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (res),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    // pack result word
    assign m_axis_tdata = {5'd0, res.ent.pid, res.ent.pflag, res.ent.particle,
                           res.ent.track, res.ent.energy, res.ent.z, res.ent.y,
                           res.ent.x, res.row, res.col};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

endmodule
`default_nettype wire
